FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the duplicate filter RTL.
// Each macro expects signals named clock and reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define SDF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Expression must never be true outside reset
`define SDF_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/sdf_pkg.sv
// Types and constants for the sequence number duplicate filter.
// No dependencies; used by every module of the block.
package sdf_pkg;

   // Operation codes carried in the op field
   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam int SEQNO_W = 16;
   localparam int STAMP_W = 32;
   localparam int COUNT_W = 32;
   localparam int ID_W    = 16;

   typedef struct packed {
      logic               op;
      logic [ID_W-1:0]    src_id;
      logic [SEQNO_W-1:0] seqno;
      logic [STAMP_W-1:0] now;
   } sdf_req_type;

   typedef struct packed {
      logic               is_duplicate;
      logic               rejected;
      logic [COUNT_W-1:0] rx_count;
   } sdf_rsp_type;

   // One history entry
   typedef struct packed {
      logic [SEQNO_W-1:0] seqno;
      logic [STAMP_W-1:0] stamp;
   } sdf_entry_type;

   // Write enables from the controller to the storage
   typedef struct packed {
      logic hist_we;
      logic cnt_we;
   } sdf_wr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MATCH,
      ST_WRITE
   } sdf_state_type;

endpackage

FILE: hw/rtl/sdf_store.sv
// History and receive count memories, one row per sender.
// Depends on sdf_pkg. Single address, synchronous read through an output register.
module sdf_store #(
   parameter int  NODES   = 64,
   parameter int  HISTORY = 4,
   localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1
) (
   input  logic                                     clock,
   input  logic [NODE_AW-1:0]                       addr,
   input  sdf_pkg::sdf_wr_type                      wr,
   input  sdf_pkg::sdf_entry_type [HISTORY-1:0]     wr_row,
   input  logic [sdf_pkg::COUNT_W-1:0]              wr_cnt,
   output sdf_pkg::sdf_entry_type [HISTORY-1:0]     rd_row,
   output logic [sdf_pkg::COUNT_W-1:0]              rd_cnt
);

   sdf_pkg::sdf_entry_type [HISTORY-1:0] hist_mem [NODES];
   logic [sdf_pkg::COUNT_W-1:0]          cnt_mem [NODES];

   sdf_pkg::sdf_entry_type [HISTORY-1:0] rd_row_ff;
   logic [sdf_pkg::COUNT_W-1:0]          rd_cnt_ff;

   // History rows: whole row read and written at once
   always_ff @(posedge clock) begin
      if (wr.hist_we) begin
         hist_mem[addr] <= wr_row;
      end
      rd_row_ff <= hist_mem[addr];
   end

   // Receive counts
   always_ff @(posedge clock) begin
      if (wr.cnt_we) begin
         cnt_mem[addr] <= wr_cnt;
      end
      rd_cnt_ff <= cnt_mem[addr];
   end

   assign rd_row = rd_row_ff;
   assign rd_cnt = rd_cnt_ff;

endmodule

FILE: hw/rtl/sdf_match.sv
// History search stage: finds the newest entry with the item's seqno and its age.
// Depends on sdf_pkg. Results are registered for the write-back stage.
module sdf_match #(
   parameter int  HISTORY = 4,
   localparam int HIST_IW = (HISTORY > 1) ? $clog2(HISTORY) : 1
) (
   input  logic                                 clock,
   input  sdf_pkg::sdf_entry_type [HISTORY-1:0] row,
   input  logic [sdf_pkg::SEQNO_W-1:0]          seqno,
   input  logic [sdf_pkg::STAMP_W-1:0]          now,
   output logic                                 hit_found,
   output logic [HIST_IW-1:0]                   hit_idx,
   output logic [sdf_pkg::STAMP_W-1:0]          age
);

   logic                          hit_found_in, hit_found_ff;
   logic [HIST_IW-1:0]            hit_idx_in, hit_idx_ff;
   logic [sdf_pkg::STAMP_W-1:0]   age_in, age_ff;

   // Priority search, newest entry wins (scan from oldest so newest overrides)
   always_comb begin
      hit_found_in = 1'b0;
      hit_idx_in   = '0;
      for (int k = HISTORY - 1; k >= 0; k--) begin
         if (row[k].seqno == seqno) begin
            hit_found_in = 1'b1;
            hit_idx_in   = HIST_IW'(k);
         end
      end
   end

   // Age of the matched entry, modulo 2^32
   assign age_in = now - row[hit_idx_in].stamp;

   always_ff @(posedge clock) begin
      hit_found_ff <= hit_found_in;
      hit_idx_ff   <= hit_idx_in;
      age_ff       <= age_in;
   end

   assign hit_found = hit_found_ff;
   assign hit_idx   = hit_idx_ff;
   assign age       = age_ff;

endmodule

FILE: hw/rtl/seqno_duplicate_filter.sv
// Sequence number duplicate filter, top level. Uses sdf_pkg, sdf_store, sdf_match.
// A packet item passes accept, memory read, history search and write-back in turn;
// its result is loaded in write-back, which waits while an earlier result is pending.
// A clear item sweeps one sender row per cycle, then waits at the last row for a free result register.
// Reset runs the same clearing pass (req_ready low); max_age resets to 0.
// The result register lets the next item be accepted while a result waits.
`include "assert_macros.svh"

module seqno_duplicate_filter #(
   parameter int NODES   = 64,
   parameter int HISTORY = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sdf_pkg::sdf_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sdf_pkg::sdf_rsp_type        rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sdf_pkg::STAMP_W-1:0] csr_data
);

   localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int HIST_IW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
   localparam logic [sdf_pkg::ID_W-1:0] NODES_ID = sdf_pkg::ID_W'(NODES);
   localparam logic [NODE_AW-1:0]       LAST_ROW = NODE_AW'(NODES - 1);

   sdf_pkg::sdf_state_type state_ff, state_in;
   sdf_pkg::sdf_req_type   req_ff, req_in;
   sdf_pkg::sdf_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NODE_AW-1:0]     clr_addr_ff, clr_addr_in;
   logic                   clr_rsp_ff, clr_rsp_in;
   logic [sdf_pkg::STAMP_W-1:0] max_age_ff, max_age_in;

   logic                   req_accept;
   logic                   id_ok;
   logic [NODE_AW-1:0]     node_idx;
   logic [NODE_AW-1:0]     mem_addr;
   sdf_pkg::sdf_wr_type    wr;
   sdf_pkg::sdf_entry_type [HISTORY-1:0] rd_row, new_row, wr_row;
   logic [sdf_pkg::COUNT_W-1:0] rd_cnt, cnt_inc, wr_cnt;
   logic                   hit_found;
   logic [HIST_IW-1:0]     hit_idx, shift_limit;
   logic [sdf_pkg::STAMP_W-1:0] age;
   logic                   dup;
   logic                   rsp_free;
   logic                   load_rsp;
   logic                   sweep_last;

   // Sender decode
   assign id_ok    = (req_ff.src_id != '0) && (req_ff.src_id <= NODES_ID);
   assign node_idx = NODE_AW'(req_ff.src_id - sdf_pkg::ID_W'(1));

   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign sweep_last = (clr_addr_ff == LAST_ROW);

   // Configuration register, always writable
   assign csr_ready  = 1'b1;
   assign max_age_in = csr_valid ? csr_data : max_age_ff;

   sdf_store #(
      .NODES   (NODES),
      .HISTORY (HISTORY)
   ) u_store (
      .clock  (clock),
      .addr   (mem_addr),
      .wr     (wr),
      .wr_row (wr_row),
      .wr_cnt (wr_cnt),
      .rd_row (rd_row),
      .rd_cnt (rd_cnt)
   );

   sdf_match #(
      .HISTORY (HISTORY)
   ) u_match (
      .clock     (clock),
      .row       (rd_row),
      .seqno     (req_ff.seqno),
      .now       (req_ff.now),
      .hit_found (hit_found),
      .hit_idx   (hit_idx),
      .age       (age)
   );

   // Duplicate decision: a fresh match, or any match when the age check is off
   assign dup = hit_found && ((max_age_ff == '0) || (age <= max_age_ff));

   // Updated row: new item at the front, older entries shift back up to the hit
   assign shift_limit = hit_found ? hit_idx : HIST_IW'(HISTORY - 1);
   always_comb begin
      new_row[0].seqno = req_ff.seqno;
      new_row[0].stamp = req_ff.now;
      for (int k = 1; k < HISTORY; k++) begin
         new_row[k] = (HIST_IW'(k) <= shift_limit) ? rd_row[k-1] : rd_row[k];
      end
   end

   assign cnt_inc = rd_cnt + sdf_pkg::COUNT_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdf_pkg::ST_CLEAR: begin
            if (sweep_last && (!clr_rsp_ff || rsp_free)) begin
               state_in = sdf_pkg::ST_IDLE;
            end
         end
         sdf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.op == sdf_pkg::OP_CLEAR) ? sdf_pkg::ST_CLEAR
                                                             : sdf_pkg::ST_READ;
            end
         end
         sdf_pkg::ST_READ:  state_in = sdf_pkg::ST_MATCH;
         sdf_pkg::ST_MATCH: state_in = sdf_pkg::ST_WRITE;
         sdf_pkg::ST_WRITE: begin
            if (rsp_free) begin
               state_in = sdf_pkg::ST_IDLE;
            end
         end
         default: state_in = sdf_pkg::ST_CLEAR;
      endcase
   end

   // Outputs of the state machine: memory access and result load
   always_comb begin
      req_ready   = 1'b0;
      mem_addr    = node_idx;
      wr          = '0;
      wr_row      = new_row;
      wr_cnt      = cnt_inc;
      load_rsp    = 1'b0;
      rsp_data_in = '0;
      unique case (state_ff)
         sdf_pkg::ST_CLEAR: begin
            mem_addr   = clr_addr_ff;
            wr.hist_we = 1'b1;
            wr.cnt_we  = 1'b1;
            wr_row     = '0;
            wr_cnt     = '0;
            load_rsp   = sweep_last && clr_rsp_ff && rsp_free;
         end
         sdf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         sdf_pkg::ST_READ, sdf_pkg::ST_MATCH: begin
            mem_addr = node_idx;
         end
         sdf_pkg::ST_WRITE: begin
            load_rsp   = rsp_free;
            wr.hist_we = rsp_free && id_ok && !dup;
            wr.cnt_we  = rsp_free && id_ok && !dup;
            rsp_data_in.is_duplicate = id_ok && dup;
            rsp_data_in.rejected     = !id_ok;
            if (!id_ok) begin
               rsp_data_in.rx_count = '0;
            end else if (dup) begin
               rsp_data_in.rx_count = rd_cnt;
            end else begin
               rsp_data_in.rx_count = cnt_inc;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Sweep control and item capture
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_rsp_in  = clr_rsp_ff;
      req_in      = req_ff;
      if (req_accept) begin
         req_in      = req_data;
         clr_addr_in = '0;
         clr_rsp_in  = (req_data.op == sdf_pkg::OP_CLEAR);
      end else if (state_ff == sdf_pkg::ST_CLEAR) begin
         if (!sweep_last) begin
            clr_addr_in = clr_addr_ff + NODE_AW'(1);
         end else if (!clr_rsp_ff || rsp_free) begin
            clr_rsp_in = 1'b0;
         end
      end
   end

   // Result register
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdf_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_age_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         max_age_ff   <= max_age_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Memory writes only in write-back or the clearing sweep
   `SDF_ASSERT(a_wr_state,
      (wr.hist_we || wr.cnt_we) |->
         (state_ff == sdf_pkg::ST_WRITE || state_ff == sdf_pkg::ST_CLEAR),
      "memory write outside write-back or sweep")
   // A result is never loaded over one still waiting
   `SDF_ASSERT(a_rsp_no_overwrite, load_rsp |-> rsp_free, "result register overwritten")
   // A counted packet always produces its result in the same cycle
   `SDF_ASSERT(a_count_has_rsp,
      (state_ff == sdf_pkg::ST_WRITE && wr.cnt_we) |-> (load_rsp && !dup),
      "count updated without result")
   // Rejected results carry no count and no duplicate flag
   `SDF_ASSERT_NEVER(a_reject_clean,
      rsp_valid_ff && rsp_data_ff.rejected &&
         (rsp_data_ff.is_duplicate || rsp_data_ff.rx_count != '0),
      "rejected result carries data")
   // No item is taken during the clearing sweep
   `SDF_ASSERT(a_sweep_blocks,
      (state_ff == sdf_pkg::ST_CLEAR) |=> !$past(req_ready),
      "item accepted during sweep")

endmodule
